// File: hdl/rccd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccd_pkg
// Shared types and constants of the robot console command decoder: word
// layouts, configuration fields, command and event codes, and key codes.
// ----------------------------------------------------------------------------
package rccd_pkg;

    // Input word: optional received byte plus five line-sensor samples.
    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [9:0] sensor_one;
        logic [9:0] sensor_two;
        logic [9:0] sensor_three;
        logic [9:0] sensor_four;
        logic [9:0] sensor_five;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [4:0]  command_code;
        logic [2:0]  event_code;
        logic [13:0] threshold_out;
        logic [3:0]  menu_out;
    } t_out_word;

    // Configuration values handed from the register file to the decoder.
    typedef struct packed {
        logic [9:0] peak_level;
        logic [9:0] threshold_margin;
    } t_cfg;

    // Register indexes.
    localparam logic REG_PEAK_LEVEL       = 1'b0;
    localparam logic REG_THRESHOLD_MARGIN = 1'b1;

    // Reset values.
    localparam logic [9:0]  PEAK_RESET   = 10'd700;
    localparam logic [9:0]  MARGIN_RESET = 10'd20;
    localparam logic [13:0] THR_RESET    = 14'd510;
    localparam logic [13:0] THR_LIMIT    = 14'd1024;
    localparam logic [9:0]  DIFF_RESET   = 10'd1000;

    // Command codes.
    localparam logic [4:0] CMD_NONE       = 5'd0;
    localparam logic [4:0] CMD_BRAKE      = 5'd1;
    localparam logic [4:0] CMD_JOG        = 5'd2;
    localparam logic [4:0] CMD_READ_BASE  = 5'd3;
    localparam logic [4:0] CMD_LEFT_BASE  = 5'd8;
    localparam logic [4:0] CMD_RIGHT_BASE = 5'd16;
    localparam logic [4:0] CMD_REV_OFFSET = 5'd4;

    // Event codes.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_UNKNOWN_KEY = 3'd1;
    localparam logic [2:0] EV_ENTRY_ERROR = 3'd2;
    localparam logic [2:0] EV_THR_SET     = 3'd3;
    localparam logic [2:0] EV_AUTO_ABORT  = 3'd4;
    localparam logic [2:0] EV_AUTO_START  = 3'd5;

    // Menu numbers as they appear on the result word.
    localparam logic [3:0] MENU_WAIT = 4'd9;
    localparam logic [3:0] MENU_SENSOR = 4'd6;
    localparam logic [3:0] MENU_LAST = 4'd13;

    // Motor speed codes.
    localparam logic [1:0] SPD_FAST   = 2'd0;
    localparam logic [1:0] SPD_MEDIUM = 2'd1;
    localparam logic [1:0] SPD_SLOW   = 2'd2;
    localparam logic [1:0] SPD_ZERO   = 2'd3;

    // Key codes.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] KEY_A    = 8'h61;
    localparam logic [7:0] KEY_B    = 8'h62;
    localparam logic [7:0] KEY_C    = 8'h63;
    localparam logic [7:0] KEY_F    = 8'h66;
    localparam logic [7:0] KEY_J    = 8'h6A;
    localparam logic [7:0] KEY_L    = 8'h6C;
    localparam logic [7:0] KEY_M    = 8'h6D;
    localparam logic [7:0] KEY_R    = 8'h72;
    localparam logic [7:0] KEY_S    = 8'h73;
    localparam logic [7:0] KEY_T    = 8'h74;
    localparam logic [7:0] KEY_U    = 8'h75;

endpackage

// File: hdl/rccd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccd_cfg_regs
// APB-style register file holding the peak level and the threshold margin.
// ----------------------------------------------------------------------------
module rccd_cfg_regs
    import rccd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [9:0] r_peak_level;
    logic [9:0] r_threshold_margin;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_level       <= PEAK_RESET;
            r_threshold_margin <= MARGIN_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_PEAK_LEVEL:       r_peak_level       <= pwdata[9:0];
                REG_THRESHOLD_MARGIN: r_threshold_margin <= pwdata[9:0];
                default:              r_peak_level       <= r_peak_level;
            endcase
        end
    end

    // Read data, zero-extended.
    always_comb begin
        unique case (reg_sel)
            REG_PEAK_LEVEL:       prdata = {22'd0, r_peak_level};
            REG_THRESHOLD_MARGIN: prdata = {22'd0, r_threshold_margin};
            default:              prdata = 32'd0;
        endcase
    end

    assign o_cfg.peak_level       = r_peak_level;
    assign o_cfg.threshold_margin = r_threshold_margin;

endmodule

// File: hdl/rccd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rccd_step
// Menu state machine, motor speed memory, threshold entry and calibration
// sweep. Processes one word per enabled cycle and returns its result.
// ----------------------------------------------------------------------------
module rccd_step
    import rccd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    typedef enum logic [3:0] {
        M_TOP    = 4'd0,
        M_MOTOR  = 4'd1,
        M_LFWD   = 4'd2,
        M_LREV   = 4'd3,
        M_RFWD   = 4'd4,
        M_RREV   = 4'd5,
        M_SENSOR = 4'd6,
        M_DIG1   = 4'd7,
        M_DIGN   = 4'd8,
        M_WAIT   = 4'd9,
        M_GAP3   = 4'd10,
        M_GAP2   = 4'd11,
        M_GAP1   = 4'd12,
        M_GAP0   = 4'd13
    } t_menu;

    t_menu       r_menu,  n_menu;
    logic [1:0]  r_left,  n_left;
    logic [1:0]  r_right, n_right;
    logic [13:0] r_thr,   n_thr;
    logic [9:0]  r_gdiff [4];
    logic [9:0]  n_gdiff [4];
    logic [9:0]  r_glvl  [4];
    logic [9:0]  n_glvl  [4];

    logic [9:0]  sens [5];
    logic [7:0]  key;
    logic        has_byte;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [4:0]  cmd;
    logic [2:0]  ev;

    // Sweep helpers.
    logic [1:0]  gap;
    logic [9:0]  sa, sb, lo, diff;
    logic [9:0]  min01, min23, min_all;

    // Motor menu helpers.
    logic        is_right, is_rev;
    logic [1:0]  spd, n_spd;
    logic [4:0]  base, off;

    assign sens[0] = i_word.sensor_one;
    assign sens[1] = i_word.sensor_two;
    assign sens[2] = i_word.sensor_three;
    assign sens[3] = i_word.sensor_four;
    assign sens[4] = i_word.sensor_five;

    // Key classification; letters fold to lower case.
    assign has_byte  = i_word.rx_valid && (i_word.rx_byte != 8'd0);
    assign key       = (i_word.rx_byte >= CH_UP_A && i_word.rx_byte <= CH_UP_Z) ?
                       (i_word.rx_byte + CH_CASE) : i_word.rx_byte;
    assign is_digit  = (i_word.rx_byte >= CH_0) && (i_word.rx_byte <= CH_9);
    assign digit_val = 4'(i_word.rx_byte - CH_0);

    // Gap compare for the current sweep state; gap 0 is sensors one and two.
    assign gap  = 2'(4'(M_GAP0) - 4'(r_menu));
    assign sa   = sens[3'(gap)];
    assign sb   = sens[3'(gap) + 3'd1];
    assign lo   = (sa < sb) ? sa : sb;
    assign diff = (sa < sb) ? (sb - sa) : (sa - sb);

    // Minimum over the levels after this word's update.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_glvl[k]  = r_glvl[k];
            n_gdiff[k] = r_gdiff[k];
        end
        if (r_menu == M_GAP3 || r_menu == M_GAP2 || r_menu == M_GAP1 ||
            r_menu == M_GAP0) begin
            if (diff < r_gdiff[gap]) begin
                n_gdiff[gap] = diff;
                n_glvl[gap]  = lo;
            end
        end else if (r_menu == M_SENSOR && has_byte && key == KEY_A &&
                     !(i_word.rx_byte >= CH_1 && i_word.rx_byte <= CH_5)) begin
            for (int k = 0; k < 4; k++) begin
                n_glvl[k]  = 10'd0;
                n_gdiff[k] = DIFF_RESET;
            end
        end
    end

    assign min01   = (n_glvl[1] < n_glvl[0]) ? n_glvl[1] : n_glvl[0];
    assign min23   = (n_glvl[3] < n_glvl[2]) ? n_glvl[3] : n_glvl[2];
    assign min_all = (min23 < min01) ? min23 : min01;

    // Motor menu decode.
    assign is_right = (r_menu == M_RFWD) || (r_menu == M_RREV);
    assign is_rev   = (r_menu == M_LREV) || (r_menu == M_RREV);
    assign spd      = is_right ? r_right : r_left;
    assign base     = is_right ? CMD_RIGHT_BASE : CMD_LEFT_BASE;
    assign off      = is_rev ? CMD_REV_OFFSET : 5'd0;

    // Next state and result of one word.
    always_comb begin
        n_menu  = r_menu;
        n_left  = r_left;
        n_right = r_right;
        n_thr   = r_thr;
        n_spd   = spd;
        cmd     = CMD_NONE;
        ev      = EV_NONE;
        unique case (r_menu)
            M_WAIT: begin
                if (sens[4] > i_cfg.peak_level) begin
                    n_menu = M_GAP3;
                end
                if (i_word.rx_valid) begin
                    n_menu = M_SENSOR;
                    ev     = EV_AUTO_ABORT;
                end
            end
            M_GAP3, M_GAP2, M_GAP1, M_GAP0: begin
                if (sa > i_cfg.peak_level && r_menu == M_GAP0) begin
                    // Sweep complete: the byte, if any, is dropped.
                    n_thr  = (min_all > i_cfg.threshold_margin) ?
                             14'(min_all - i_cfg.threshold_margin) : 14'd0;
                    n_menu = M_SENSOR;
                    ev     = EV_THR_SET;
                end else if (i_word.rx_valid) begin
                    n_menu = M_SENSOR;
                    ev     = EV_AUTO_ABORT;
                end else if (sa > i_cfg.peak_level) begin
                    n_menu = t_menu'(4'(r_menu) + 4'd1);
                end
            end
            M_MOTOR: begin
                if (has_byte) begin
                    priority if (key == KEY_L) n_menu = M_LFWD;
                    else if (key == KEY_R) n_menu = M_RFWD;
                    else if (key == KEY_B) cmd = CMD_BRAKE;
                    else if (key == KEY_J) cmd = CMD_JOG;
                    else if (key == KEY_U) n_menu = M_TOP;
                    else begin
                        n_menu = M_TOP;
                        ev     = EV_UNKNOWN_KEY;
                    end
                end
            end
            M_LFWD, M_LREV, M_RFWD, M_RREV: begin
                if (has_byte) begin
                    unique case (key)
                        KEY_F: begin
                            n_spd = SPD_FAST;
                            cmd   = base + off;
                        end
                        KEY_M: begin
                            n_spd = SPD_MEDIUM;
                            cmd   = base + off + 5'd1;
                        end
                        KEY_S: begin
                            n_spd = SPD_SLOW;
                            cmd   = base + off + 5'd2;
                        end
                        KEY_C: begin
                            n_spd = SPD_ZERO;
                            cmd   = base + off + 5'd3;
                        end
                        CH_LT: begin
                            if (!is_rev) begin
                                cmd    = base + CMD_REV_OFFSET + 5'(spd);
                                n_menu = is_right ? M_RREV : M_LREV;
                            end
                        end
                        CH_GT: begin
                            if (is_rev) begin
                                cmd    = base + 5'(spd);
                                n_menu = is_right ? M_RFWD : M_LFWD;
                            end
                        end
                        KEY_U: n_menu = M_MOTOR;
                        default: ev = EV_UNKNOWN_KEY;
                    endcase
                    if (is_right) begin
                        n_right = n_spd;
                    end else begin
                        n_left = n_spd;
                    end
                end
            end
            M_SENSOR: begin
                if (has_byte) begin
                    priority if (i_word.rx_byte >= CH_1 && i_word.rx_byte <= CH_5) begin
                        cmd = CMD_READ_BASE + 5'(i_word.rx_byte - CH_1);
                    end else if (key == KEY_T) begin
                        n_menu = M_DIG1;
                    end else if (key == KEY_A) begin
                        n_menu = M_WAIT;
                        ev     = EV_AUTO_START;
                    end else if (key == KEY_U) begin
                        n_menu = M_TOP;
                    end else begin
                        ev = EV_UNKNOWN_KEY;
                    end
                end
            end
            M_DIG1: begin
                if (has_byte) begin
                    if (is_digit) begin
                        n_thr  = 14'(digit_val);
                        n_menu = M_DIGN;
                    end else begin
                        ev = EV_ENTRY_ERROR;
                    end
                end
            end
            M_DIGN: begin
                if (has_byte) begin
                    priority if (r_thr >= THR_LIMIT) begin
                        n_thr  = THR_RESET;
                        n_menu = M_DIG1;
                        ev     = EV_ENTRY_ERROR;
                    end else if (is_digit) begin
                        // Value times ten by shift and add; stays below 10240.
                        n_thr = (14'(r_thr[9:0]) << 3) + (14'(r_thr[9:0]) << 1) +
                                14'(digit_val);
                    end else if (r_thr != 14'd0) begin
                        n_menu = M_SENSOR;
                        ev     = EV_THR_SET;
                    end else begin
                        n_thr  = THR_RESET;
                        n_menu = M_DIG1;
                        ev     = EV_ENTRY_ERROR;
                    end
                end
            end
            default: begin
                if (has_byte) begin
                    priority if (key == KEY_M) n_menu = M_MOTOR;
                    else if (key == KEY_S) n_menu = M_SENSOR;
                    else n_menu = M_TOP;
                end
            end
        endcase
    end

    assign o_result.command_code  = cmd;
    assign o_result.event_code    = ev;
    assign o_result.threshold_out = n_thr;
    assign o_result.menu_out      = 4'(n_menu);

    // Decoder state, updated once for each word taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu  <= M_TOP;
            r_left  <= SPD_ZERO;
            r_right <= SPD_ZERO;
            r_thr   <= THR_RESET;
            for (int k = 0; k < 4; k++) begin
                r_gdiff[k] <= DIFF_RESET;
                r_glvl[k]  <= 10'd0;
            end
        end else if (i_fire) begin
            r_menu  <= n_menu;
            r_left  <= n_left;
            r_right <= n_right;
            r_thr   <= n_thr;
            for (int k = 0; k < 4; k++) begin
                r_gdiff[k] <= n_gdiff[k];
                r_glvl[k]  <= n_glvl[k];
            end
        end
    end

    // A finished sweep always lands in the sensor menu.
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_menu == M_GAP0 && sa > i_cfg.peak_level) |=> (r_menu == M_SENSOR))
        else $error("sweep end did not return to the sensor menu");

    // Entering auto mode clears the gap records; checked on differences 0 and 3 and level 0.
    a_auto_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_menu == M_SENSOR && n_menu == M_WAIT) |=>
        (r_gdiff[0] == DIFF_RESET && r_gdiff[3] == DIFF_RESET && r_glvl[0] == 10'd0))
        else $error("gap records not cleared at auto start");

    // The state only moves when a word is processed.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_menu) && $stable(r_thr)))
        else $error("decoder state changed without a word");

endmodule

// File: hdl/robot_console_command_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_console_command_decoder_core
// Console command decoder: input word register, one-pass decode of menu,
// motor, threshold entry and sensor sweep, and a result word register.
// Flow: a word taken into the input word register is decoded, and its result
// is captured in the result word register, from which the consumer takes it.
// Throughput: one word per cycle while the output is not stalled.
// The input register keeps taking words while a result waits in the output
// register, and stalls only when both are full.
// Reset (synchronous, active low): top menu, both speeds zero, threshold 510,
// peak level 700, margin 20, both registers empty.
// ----------------------------------------------------------------------------
module robot_console_command_decoder_core
    import rccd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word step_result;
    t_cfg      cfg;
    logic      advance;
    logic      in_take;

    rccd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rccd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // The held word moves on when the output register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A held word that cannot move stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input word lost while stalled");

    // Menu numbers stay within the defined menus.
    a_menu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.menu_out <= MENU_LAST))
        else $error("menu number out of range");

    // No motor or sensor command is issued from auto mode.
    a_auto_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.menu_out >= MENU_WAIT) |->
        (r_out_word.command_code == CMD_NONE))
        else $error("command issued in auto mode");

    // A threshold set always lands in the sensor menu.
    a_thr_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.event_code == EV_THR_SET) |->
        (r_out_word.menu_out == MENU_SENSOR))
        else $error("threshold set outside the sensor menu");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the robot console command decoder. A queue of input
// words, directed and then random menu walks, threshold entries and sensor
// sweeps, feeds a clocked driver. Each accepted word runs through a local
// decoder predictor, and a clocked monitor checks every result word against
// the oldest prediction. The configuration registers are rewritten between
// phases over APB and read back. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rccd_pkg::*;

    // Menu numbers not named in the package.
    localparam logic [3:0] MN_TOP   = 4'd0;
    localparam logic [3:0] MN_MOTOR = 4'd1;
    localparam logic [3:0] MN_LFWD  = 4'd2;
    localparam logic [3:0] MN_LREV  = 4'd3;
    localparam logic [3:0] MN_RFWD  = 4'd4;
    localparam logic [3:0] MN_RREV  = 4'd5;
    localparam logic [3:0] MN_DIG1  = 4'd7;
    localparam logic [3:0] MN_DIGN  = 4'd8;
    localparam logic [3:0] MN_GAP3  = 4'd10;

    localparam logic [7:0] KEY_CR = 8'h0D;
    localparam logic [7:0] KEY_X  = 8'h78;
    localparam logic [9:0] LEVEL_MAX = 10'h3FF;

    localparam int IDLE_PCT       = 29;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 225;
    localparam int DRAIN_CYCLES   = 8;

    // Decoder state as the predictor tracks it.
    typedef struct packed {
        logic [3:0]      menu;
        logic [1:0]      lspd;
        logic [1:0]      rspd;
        logic [13:0]     thr;
        logic [3:0][9:0] gdiff;
        logic [3:0][9:0] glvl;
    } t_dec_state;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_word    in_word   = '0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic [31:0] prdata;
    logic        pready;

    t_in_word   send_q[$];
    t_out_word  reply_q[$];
    t_dec_state dut_view_st;
    t_dec_state plan_st;
    logic [9:0] cfg_peak;
    logic [9:0] cfg_margin;
    t_out_word  pred_word;
    t_out_word  want_word;

    int  cyc        = 0;
    int  idle_cyc   = 0;
    int  fails      = 0;
    int  n_added    = 0;
    int  n_results  = 0;
    int  n_settings = 0;
    int  n_cmds     = 0;
    int  n_thr_set  = 0;
    int  n_auto     = 0;
    int  n_abort    = 0;
    logic quiet;

    robot_console_command_decoder_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // One long stretch in which neither side idles.
    assign quiet = (cyc >= 900) && (cyc < 1500);

    function automatic t_dec_state reset_state();
        t_dec_state st;
        st.menu = MN_TOP;
        st.lspd = SPD_ZERO;
        st.rspd = SPD_ZERO;
        st.thr  = THR_RESET;
        for (int k = 0; k < 4; k++) begin
            st.gdiff[k] = DIFF_RESET;
            st.glvl[k]  = '0;
        end
        return st;
    endfunction

    // Key handling inside one of the four motor-direction menus.
    function automatic void motor_key(inout logic [1:0] spd, inout logic [3:0] menu,
                                      inout t_out_word r, input logic [7:0] key,
                                      input logic [4:0] base, input logic rev,
                                      input logic [3:0] fwd_menu);
        logic [4:0] off;
        off = rev ? CMD_REV_OFFSET : 5'd0;
        case (key)
            KEY_F: begin
                spd = SPD_FAST;
                r.command_code = base + off + 5'(spd);
            end
            KEY_M: begin
                spd = SPD_MEDIUM;
                r.command_code = base + off + 5'(spd);
            end
            KEY_S: begin
                spd = SPD_SLOW;
                r.command_code = base + off + 5'(spd);
            end
            KEY_C: begin
                spd = SPD_ZERO;
                r.command_code = base + off + 5'(spd);
            end
            CH_LT: begin
                if (!rev) begin
                    r.command_code = base + CMD_REV_OFFSET + 5'(spd);
                    menu = fwd_menu + 4'd1;
                end
            end
            CH_GT: begin
                if (rev) begin
                    r.command_code = base + 5'(spd);
                    menu = fwd_menu;
                end
            end
            KEY_U: menu = MN_MOTOR;
            default: r.event_code = EV_UNKNOWN_KEY;
        endcase
    endfunction

    // Predicts the result word of one input word and advances the state.
    function automatic t_out_word console_step(inout t_dec_state st, input t_in_word w);
        t_out_word   r;
        logic [9:0]  s [5];
        logic [9:0]  a, b, lo, df, mn;
        logic [7:0]  key;
        logic [13:0] dval;
        logic        dig;
        logic        done;
        int          g;
        r = '0;
        r.command_code = CMD_NONE;
        r.event_code   = EV_NONE;
        s[0] = w.sensor_one;
        s[1] = w.sensor_two;
        s[2] = w.sensor_three;
        s[3] = w.sensor_four;
        s[4] = w.sensor_five;
        if (st.menu >= MENU_WAIT && st.menu <= MENU_LAST) begin
            // Sweep of the four sensor gaps, right to left.
            done = 1'b0;
            if (st.menu == MENU_WAIT) begin
                if (s[4] > cfg_peak) st.menu = MN_GAP3;
            end else begin
                g  = int'(MENU_LAST - st.menu);
                a  = s[g];
                b  = s[g+1];
                lo = (a < b) ? a : b;
                df = (a < b) ? b - a : a - b;
                if (df < st.gdiff[g]) begin
                    st.gdiff[g] = df;
                    st.glvl[g]  = lo;
                end
                if (s[g] > cfg_peak) begin
                    if (g == 0) begin
                        mn = st.glvl[0];
                        for (int k = 1; k < 4; k++) if (st.glvl[k] < mn) mn = st.glvl[k];
                        st.thr = (mn > cfg_margin) ? 14'(mn - cfg_margin) : 14'd0;
                        st.menu = MENU_SENSOR;
                        r.event_code = EV_THR_SET;
                        done = 1'b1;
                    end else begin
                        st.menu = st.menu + 4'd1;
                    end
                end
            end
            // Any received word aborts, except on the step that ends the sweep.
            if (w.rx_valid && !done) begin
                st.menu = MENU_SENSOR;
                r.event_code = EV_AUTO_ABORT;
            end
        end else if (w.rx_valid && w.rx_byte != 8'd0) begin
            key  = (w.rx_byte >= CH_UP_A && w.rx_byte <= CH_UP_Z) ? w.rx_byte + CH_CASE
                                                                 : w.rx_byte;
            dig  = (w.rx_byte >= CH_0) && (w.rx_byte <= CH_9);
            dval = 14'(w.rx_byte - CH_0);
            case (st.menu)
                MN_MOTOR: begin
                    if (key == KEY_L) st.menu = MN_LFWD;
                    else if (key == KEY_R) st.menu = MN_RFWD;
                    else if (key == KEY_B) r.command_code = CMD_BRAKE;
                    else if (key == KEY_J) r.command_code = CMD_JOG;
                    else if (key == KEY_U) st.menu = MN_TOP;
                    else begin
                        st.menu = MN_TOP;
                        r.event_code = EV_UNKNOWN_KEY;
                    end
                end
                MN_LFWD: motor_key(st.lspd, st.menu, r, key, CMD_LEFT_BASE, 1'b0, MN_LFWD);
                MN_LREV: motor_key(st.lspd, st.menu, r, key, CMD_LEFT_BASE, 1'b1, MN_LFWD);
                MN_RFWD: motor_key(st.rspd, st.menu, r, key, CMD_RIGHT_BASE, 1'b0, MN_RFWD);
                MN_RREV: motor_key(st.rspd, st.menu, r, key, CMD_RIGHT_BASE, 1'b1, MN_RFWD);
                MENU_SENSOR: begin
                    if (w.rx_byte >= CH_1 && w.rx_byte <= CH_5) begin
                        r.command_code = CMD_READ_BASE + 5'(w.rx_byte - CH_1);
                    end else if (key == KEY_T) begin
                        st.menu = MN_DIG1;
                    end else if (key == KEY_A) begin
                        for (int k = 0; k < 4; k++) begin
                            st.gdiff[k] = DIFF_RESET;
                            st.glvl[k]  = '0;
                        end
                        st.menu = MENU_WAIT;
                        r.event_code = EV_AUTO_START;
                    end else if (key == KEY_U) begin
                        st.menu = MN_TOP;
                    end else begin
                        r.event_code = EV_UNKNOWN_KEY;
                    end
                end
                MN_DIG1: begin
                    if (dig) begin
                        st.thr  = dval;
                        st.menu = MN_DIGN;
                    end else begin
                        r.event_code = EV_ENTRY_ERROR;
                    end
                end
                MN_DIGN: begin
                    if (st.thr < THR_LIMIT && dig) begin
                        st.thr = st.thr * 14'd10 + dval;
                    end else if (st.thr < THR_LIMIT && st.thr != 14'd0) begin
                        st.menu = MENU_SENSOR;
                        r.event_code = EV_THR_SET;
                    end else begin
                        // A zero value or one past the limit restarts the entry.
                        st.thr  = THR_RESET;
                        st.menu = MN_DIG1;
                        r.event_code = EV_ENTRY_ERROR;
                    end
                end
                default: begin
                    if (key == KEY_M) st.menu = MN_MOTOR;
                    else if (key == KEY_S) st.menu = MENU_SENSOR;
                    else st.menu = MN_TOP;
                end
            endcase
        end
        r.threshold_out = st.thr;
        r.menu_out      = st.menu;
        return r;
    endfunction

    function automatic logic [9:0] rand_level();
        case ($urandom_range(9))
            0: return 10'd0;
            1: return LEVEL_MAX;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [9:0] over_peak();
        if (cfg_peak == LEVEL_MAX) return LEVEL_MAX;
        return 10'($urandom_range(1023, int'(cfg_peak) + 1));
    endfunction

    function automatic logic [7:0] with_case(input logic [7:0] k);
        if (k >= KEY_A && k <= KEY_A + 8'd25 && $urandom_range(1) == 1) return k - CH_CASE;
        return k;
    endfunction

    // Picks a random word that mostly makes sense in the given menu.
    function automatic t_in_word gen_word(input logic [3:0] menu);
        t_in_word w;
        int       r;
        int       pick;
        int       abort_pct;
        w.sensor_one   = rand_level();
        w.sensor_two   = rand_level();
        w.sensor_three = rand_level();
        w.sensor_four  = rand_level();
        w.sensor_five  = rand_level();
        w.rx_valid     = 1'b1;
        w.rx_byte      = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (menu >= MENU_WAIT && menu <= MENU_LAST) begin
            // With the peak at its top the sweep cannot move, so abort more often.
            abort_pct = (cfg_peak == LEVEL_MAX) ? 25 : 4;
            if (r < abort_pct) begin
                if ($urandom_range(2) == 0) w.rx_byte = 8'd0;
            end else begin
                w.rx_valid = 1'b0;
            end
            if ($urandom_range(99) < 35) begin
                if (menu == MENU_WAIT) begin
                    w.sensor_five = over_peak();
                end else begin
                    case (int'(MENU_LAST - menu))
                        0: w.sensor_one   = over_peak();
                        1: w.sensor_two   = over_peak();
                        2: w.sensor_three = over_peak();
                        default: w.sensor_four = over_peak();
                    endcase
                end
            end
        end else if (r < 6) begin
            w.rx_valid = 1'($urandom_range(1));
        end else if (r < 14) begin
            if ($urandom_range(1) == 1) w.rx_valid = 1'b0;
            else w.rx_byte = 8'd0;
        end else begin
            pick = $urandom_range(9);
            case (menu)
                MN_MOTOR: begin
                    case (pick)
                        0, 1, 2: w.rx_byte = KEY_L;
                        3, 4, 5: w.rx_byte = KEY_R;
                        6: w.rx_byte = KEY_B;
                        7: w.rx_byte = KEY_J;
                        8: w.rx_byte = KEY_U;
                        default: ;
                    endcase
                end
                MN_LFWD, MN_LREV, MN_RFWD, MN_RREV: begin
                    case (pick)
                        0: w.rx_byte = KEY_F;
                        1: w.rx_byte = KEY_M;
                        2: w.rx_byte = KEY_S;
                        3: w.rx_byte = KEY_C;
                        4, 5: w.rx_byte = CH_LT;
                        6, 7: w.rx_byte = CH_GT;
                        8: w.rx_byte = KEY_U;
                        default: ;
                    endcase
                end
                MENU_SENSOR: begin
                    case (pick)
                        0, 1: w.rx_byte = CH_1 + 8'($urandom_range(4));
                        2, 3, 4: w.rx_byte = KEY_T;
                        5, 6: w.rx_byte = KEY_A;
                        7: w.rx_byte = KEY_U;
                        default: ;
                    endcase
                end
                MN_DIG1: begin
                    if (pick < 9) w.rx_byte = CH_0 + 8'($urandom_range(9));
                end
                MN_DIGN: begin
                    if (pick < 5) w.rx_byte = CH_0 + 8'($urandom_range(9));
                    else if (pick < 9) w.rx_byte = KEY_CR;
                end
                default: begin
                    if (pick < 4) w.rx_byte = KEY_M;
                    else if (pick < 9) w.rx_byte = KEY_S;
                end
            endcase
            w.rx_byte = with_case(w.rx_byte);
        end
        return w;
    endfunction

    function automatic t_in_word key_word(input logic [7:0] ch);
        t_in_word w;
        w.rx_valid     = 1'b1;
        w.rx_byte      = ch;
        w.sensor_one   = rand_level();
        w.sensor_two   = rand_level();
        w.sensor_three = rand_level();
        w.sensor_four  = rand_level();
        w.sensor_five  = rand_level();
        return w;
    endfunction

    // Sensors all over a peak of 700, with gap lows of 800, 750, 720 and 710.
    function automatic t_in_word sweep_word(input logic rx, input logic [7:0] ch);
        t_in_word w;
        w.rx_valid     = rx;
        w.rx_byte      = ch;
        w.sensor_one   = 10'd1000;
        w.sensor_two   = 10'd800;
        w.sensor_three = 10'd750;
        w.sensor_four  = 10'd720;
        w.sensor_five  = 10'd710;
        return w;
    endfunction

    function automatic t_in_word level_word(input logic rx, input logic [7:0] ch,
                                            input logic [9:0] lvl);
        t_in_word w;
        w.rx_valid     = rx;
        w.rx_byte      = ch;
        w.sensor_one   = lvl;
        w.sensor_two   = lvl;
        w.sensor_three = lvl;
        w.sensor_four  = lvl;
        w.sensor_five  = lvl;
        return w;
    endfunction

    task automatic add_word(input t_in_word w);
        t_out_word r;
        r = console_step(plan_st, w);
        send_q.push_back(w);
        n_added++;
    endtask

    // APB write of one register, then a back-to-back read that checks it.
    task automatic program_reg(input logic idx, input logic [9:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {22'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {22'd0, val}) begin
            fails++;
            $display("%0t ns: register %0d read back, expected %0d, actual %0d",
                     $time, idx, val, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [9:0] pk, input logic [9:0] mg);
        program_reg(REG_PEAK_LEVEL, pk);
        program_reg(REG_THRESHOLD_MARGIN, mg);
        cfg_peak   = pk;
        cfg_margin = mg;
        n_settings++;
    endtask

    // Waits until every queued word has produced its result, then a little more.
    task automatic drain();
        while (n_results < n_added) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [13:0] e,
                               input logic [13:0] a);
        if (a !== e) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        end
    endtask

    // Driver: presents queued words and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                pred_word = console_step(dut_view_st, in_word);
                reply_q.push_back(pred_word);
                if (pred_word.command_code != CMD_NONE) n_cmds++;
                if (pred_word.event_code == EV_THR_SET) n_thr_set++;
                if (pred_word.event_code == EV_AUTO_START) n_auto++;
                if (pred_word.event_code == EV_AUTO_ABORT) n_abort++;
            end
            if (!in_valid || !o_in_stall) begin
                if (send_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    in_word  <= send_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stall, result checks and the watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (reply_q.size() == 0) begin
                fails++;
                $display("%0t ns: result with none expected, expected none, actual %h",
                         $time, o_out_word);
            end else begin
                want_word = reply_q.pop_front();
                check_field("command_code", 14'(want_word.command_code),
                            14'(o_out_word.command_code));
                check_field("event_code", 14'(want_word.event_code),
                            14'(o_out_word.event_code));
                check_field("threshold_out", want_word.threshold_out,
                            o_out_word.threshold_out);
                check_field("menu_out", 14'(want_word.menu_out), 14'(o_out_word.menu_out));
            end
        end
        if (!i_rst_n || psel || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cyc <= 0;
        end else if (idle_cyc + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // Stimulus: reset, a directed walk, then random phases at several settings.
    initial begin
        logic [9:0] pk;
        logic [9:0] mg;
        dut_view_st = reset_state();
        plan_st     = reset_state();
        cfg_peak    = PEAK_RESET;
        cfg_margin  = MARGIN_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The margin is above every gap level so the sweep saturates at zero.
        apply_config(10'd700, 10'd1023);
        add_word(level_word(1'b0, 8'hFF, LEVEL_MAX));   // no byte
        add_word(level_word(1'b1, 8'd0, 10'd0));        // zero byte ignored
        add_word(key_word(KEY_X));                      // other key in top menu
        add_word(key_word(KEY_M - CH_CASE));
        add_word(key_word(KEY_X));                      // unknown key leaves motor menu
        add_word(key_word(KEY_M));
        add_word(key_word(KEY_B));
        add_word(key_word(KEY_R));
        add_word(key_word(KEY_S - CH_CASE));            // right forward slow
        add_word(key_word(CH_LT));                      // reverse keeps slow
        add_word(key_word(KEY_X));                      // unknown key stays in menu
        add_word(key_word(CH_GT));
        add_word(key_word(KEY_U));
        add_word(key_word(KEY_U));
        add_word(key_word(KEY_S));
        add_word(key_word(KEY_T));
        add_word(key_word(KEY_X));                      // non-digit as first character
        add_word(key_word(CH_0));
        add_word(key_word(KEY_CR));                     // zero value restarts entry
        repeat (4) add_word(key_word(CH_9));
        add_word(key_word(CH_1));                       // value past the limit
        add_word(key_word(CH_0 + 8'd7));
        add_word(key_word(KEY_CR));                     // terminator sets threshold
        add_word(key_word(KEY_A - CH_CASE));
        repeat (4) add_word(sweep_word(1'b0, 8'd0));
        add_word(sweep_word(1'b1, KEY_X));              // byte lost on the final step
        add_word(key_word(KEY_A));
        add_word(level_word(1'b1, 8'd0, 10'd0));        // abort with a zero byte
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin pk = PEAK_RESET; mg = MARGIN_RESET; end
                1: begin pk = 10'd0;      mg = 10'd0;        end
                2: begin pk = LEVEL_MAX;  mg = LEVEL_MAX;    end
                5: begin pk = 10'd512;    mg = 10'($urandom_range(100)); end
                default: begin
                    pk = 10'($urandom_range(1023));
                    mg = 10'($urandom_range(1023));
                end
            endcase
            apply_config(pk, mg);
            repeat (PHASE_ITEMS) add_word(gen_word(plan_st.menu));
            drain();
        end

        $display("Checked %0d result words over %0d register settings: %0d commands,",
                 n_results, n_settings, n_cmds);
        $display("%0d thresholds set, %0d sweeps started and %0d aborted.",
                 n_thr_set, n_auto, n_abort);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
